FILE: sv/dense_level_id_hash_map_macros.svh
// ----------------------------------------------------------------------------
// Dense level ID hash map - assertion macros
// Shared concurrent assertion forms for the checker.
// ----------------------------------------------------------------------------
`ifndef DENSE_LEVEL_ID_HASH_MAP_MACROS_SVH
`define DENSE_LEVEL_ID_HASH_MAP_MACROS_SVH

// same-cycle implication, reset masked
`define DLHM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("dlhm check failed");

// next-cycle implication, reset masked
`define DLHM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dlhm check failed");

`endif

FILE: sv/dlhm_pkg.sv
// ----------------------------------------------------------------------------
// dlhm_pkg
// Types and constants shared by the dense level ID hash map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlhm_pkg;

	localparam int TABLE_SLOTS = 1024;
	localparam int SLOT_AW     = $clog2(TABLE_SLOTS);      // slot / tally address
	localparam int SLOT_CNT_W  = $clog2(TABLE_SLOTS + 1);  // 1..TABLE_SLOTS
	localparam int KEY_W       = 32;
	localparam int LEVEL_W     = 11;
	localparam int COUNT_W     = 32;
	localparam int CFG_W       = 11;

	localparam logic [31:0] HASH_MULT = 32'd2654435761;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// remainder unit: bits retired per cycle and steps per hash
	localparam int MOD_DIGIT = 4;
	localparam int MOD_STEPS = 32 / MOD_DIGIT;
	localparam int MOD_CW    = $clog2(MOD_STEPS);

	typedef struct packed {
		logic               valid;
		logic [LEVEL_W-1:0] level;
		logic [KEY_W-1:0]   key;
	} slot_entry_t;

	typedef struct packed {
		logic               done;
		logic [SLOT_AW-1:0] rem;
	} mod_stat_t;

endpackage

FILE: sv/dense_level_id_hash_map.sv
// Steps: the input transfer registers the hash product; the remainder unit then gives
//   the home slot, read in ST_HASH and compared in ST_CHECK; each extra probe reads one
//   more slot; ST_TALLY follows for an existing key. Count read: ST_CNT_RD, then ST_CNT.
// Throughput: one item at a time; next input taken from the cycle the result goes valid.
// Reset: async, active low; then a pass over all 1024 slots clears the valid bits, no
//   input transfer taken meanwhile (config writes still accepted).
// ----------------------------------------------------------------------------
// dense_level_id_hash_map
// Maps 32-bit keys to dense level numbers (1, 2, ...) by first appearance, using
// a multiplicative hash, linear probing and per-level saturating counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dense_level_id_hash_map (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: slots_in_use
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // [31:0] key, [42:32] level_index, [47:43] zero
	input  logic        s_tuser,   // [0] func
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // [10:0] level, [42:11] level_count,
	                               // [53:43] distinct_levels, [55:54] zero
	output logic [1:0]  m_tuser    // [0] is_new, [1] table_full
);

	localparam int AW  = dlhm_pkg::SLOT_AW;
	localparam int CW  = dlhm_pkg::SLOT_CNT_W;
	localparam int LW  = dlhm_pkg::LEVEL_W;
	localparam int NW  = dlhm_pkg::COUNT_W;

	// FSM codes
	localparam logic [2:0] ST_CLEAR  = 3'd0;  // sweep slot RAM valid bits
	localparam logic [2:0] ST_IDLE   = 3'd1;  // wait for an input transfer
	localparam logic [2:0] ST_MUL    = 3'd2;  // hash product ready, start remainder
	localparam logic [2:0] ST_HASH   = 3'd3;  // wait for home slot, then read it
	localparam logic [2:0] ST_CHECK  = 3'd4;  // compare slot, probe on
	localparam logic [2:0] ST_TALLY  = 3'd5;  // bump existing level's count
	localparam logic [2:0] ST_CNT_RD = 3'd6;  // issue count read
	localparam logic [2:0] ST_CNT    = 3'd7;  // return count

	logic [2:0]            state_q;
	logic [AW-1:0]         clr_q;
	logic [dlhm_pkg::CFG_W-1:0] slots_q;
	logic [LW-1:0]         levels_used_q;

	// item registers
	logic [dlhm_pkg::KEY_W-1:0] key_q;
	logic [LW-1:0]         lidx_q;
	logic [31:0]           hash_q;
	logic [AW-1:0]         pos_q;
	logic [CW-1:0]         n_q;       // probes done
	logic [LW-1:0]         lvl_q;

	// result register
	logic                  m_tvalid_q;
	logic [55:0]           m_tdata_q;
	logic [1:0]            m_tuser_q;

	// effective slot count, clamped to 1..TABLE_SLOTS
	logic [CW-1:0]         m_eff;
	always_comb begin
		priority if (slots_q == '0) begin
			m_eff = CW'(1);
		end else if (CW'(slots_q) > CW'(dlhm_pkg::TABLE_SLOTS)) begin
			m_eff = CW'(dlhm_pkg::TABLE_SLOTS);
		end else begin
			m_eff = CW'(slots_q);
		end
	end

	// remainder unit
	dlhm_pkg::mod_stat_t mod_stat;

	dlhm_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == ST_MUL),
		.dividend (hash_q),
		.divisor  (m_eff),
		.stat     (mod_stat)
	);

	// slot RAM: {valid, level, key}
	logic                  slot_we, slot_re;
	logic [AW-1:0]         slot_waddr, slot_raddr;
	dlhm_pkg::slot_entry_t slot_wdata, slot_rd;

	dlhm_ram #(
		.WIDTH ($bits(dlhm_pkg::slot_entry_t)),
		.DEPTH (dlhm_pkg::TABLE_SLOTS)
	) u_slot_ram (
		.clk   (clk),
		.we    (slot_we),
		.waddr (slot_waddr),
		.wdata (slot_wdata),
		.re    (slot_re),
		.raddr (slot_raddr),
		.rdata (slot_rd)
	);

	// tally RAM: per-level counts; level L lives at L-1. Levels above
	// levels_used were never written, a new level is written with 1 directly.
	logic                  tally_we, tally_re;
	logic [AW-1:0]         tally_waddr, tally_raddr;
	logic [NW-1:0]         tally_wdata, tally_rd;

	dlhm_ram #(
		.WIDTH (NW),
		.DEPTH (dlhm_pkg::TABLE_SLOTS)
	) u_tally_ram (
		.clk   (clk),
		.we    (tally_we),
		.waddr (tally_waddr),
		.wdata (tally_wdata),
		.re    (tally_re),
		.raddr (tally_raddr),
		.rdata (tally_rd)
	);

	// decode / datapath helpers
	logic                  out_free;
	logic                  s_xfer;
	logic                  key_hit;
	logic [CW-1:0]         pos_inc;
	logic [AW-1:0]         pos_nxt;
	logic                  last_probe;
	logic [LW-1:0]         lvl_new;
	logic [NW-1:0]         tally_inc;
	logic                  lidx_ok;

	assign out_free   = !m_tvalid_q || m_tready;
	assign s_tready   = (state_q == ST_IDLE);
	assign s_xfer     = s_tvalid && s_tready;
	assign key_hit    = (slot_rd.key == key_q);
	assign pos_inc    = CW'(pos_q) + 1'b1;
	assign pos_nxt    = (pos_inc == m_eff) ? '0 : pos_inc[AW-1:0];
	assign last_probe = ((n_q + 1'b1) == m_eff);
	assign lvl_new    = levels_used_q + 1'b1;
	assign tally_inc  = (tally_rd == dlhm_pkg::COUNT_MAX) ? tally_rd : tally_rd + 1'b1;
	assign lidx_ok    = (lidx_q != '0) && (lidx_q <= levels_used_q);

	// events that leave a result this cycle
	logic                  fin_new, fin_full, fin_tally, fin_cnt;
	assign fin_new   = (state_q == ST_CHECK) && !slot_rd.valid && out_free;
	assign fin_full  = (state_q == ST_CHECK) && slot_rd.valid && !key_hit &&
	                   last_probe && out_free;
	assign fin_tally = (state_q == ST_TALLY) && out_free;
	assign fin_cnt   = (state_q == ST_CNT) && out_free;

	// memory port control
	always_comb begin
		slot_we     = 1'b0;
		slot_waddr  = pos_q;
		slot_wdata  = '{valid: 1'b1, level: lvl_new, key: key_q};
		slot_re     = 1'b0;
		slot_raddr  = pos_nxt;
		tally_we    = 1'b0;
		tally_waddr = AW'(lvl_q - 1'b1);
		tally_wdata = tally_inc;
		tally_re    = 1'b0;
		tally_raddr = AW'(lidx_q - 1'b1);
		unique case (state_q)
			ST_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				slot_wdata = '{valid: 1'b0, level: '0, key: '0};
			end
			ST_HASH: begin
				slot_re    = mod_stat.done;
				slot_raddr = mod_stat.rem;
			end
			ST_CHECK: begin
				if (fin_new) begin
					slot_we     = 1'b1;
					tally_we    = 1'b1;
					tally_waddr = AW'(levels_used_q);
					tally_wdata = NW'(1);
				end else if (slot_rd.valid && key_hit) begin
					tally_re    = 1'b1;
					tally_raddr = AW'(slot_rd.level - 1'b1);
				end else if (slot_rd.valid && !last_probe) begin
					slot_re = 1'b1;
				end
			end
			ST_TALLY: begin
				tally_we = fin_tally;
			end
			ST_CNT_RD: begin
				tally_re = 1'b1;
			end
			ST_IDLE, ST_MUL, ST_CNT: begin
			end
			default: begin
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_q         <= '0;
			slots_q       <= dlhm_pkg::CFG_W'(dlhm_pkg::TABLE_SLOTS);
			levels_used_q <= '0;
			m_tvalid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				slots_q <= cfg_wdata;
			end
			if (fin_new || fin_full || fin_tally || fin_cnt) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (fin_new) begin
				levels_used_q <= lvl_new;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(dlhm_pkg::TABLE_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_xfer) begin
						state_q <= s_tuser ? ST_CNT_RD : ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_HASH;
				end
				ST_HASH: begin
					if (mod_stat.done) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (fin_new || fin_full) begin
						state_q <= ST_IDLE;
					end else if (slot_rd.valid && key_hit) begin
						state_q <= ST_TALLY;
					end
				end
				ST_TALLY: begin
					if (fin_tally) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CNT_RD: begin
					state_q <= ST_CNT;
				end
				ST_CNT: begin
					if (fin_cnt) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_xfer) begin
			key_q  <= s_tdata[31:0];
			lidx_q <= s_tdata[42:32];
			// multiplicative hash, low 32 bits of the product
			hash_q <= 32'(s_tdata[31:0] * dlhm_pkg::HASH_MULT);
		end
		if (state_q == ST_HASH && mod_stat.done) begin
			pos_q <= mod_stat.rem;
			n_q   <= '0;
		end
		if (state_q == ST_CHECK && slot_rd.valid) begin
			if (key_hit) begin
				lvl_q <= slot_rd.level;
			end else if (!last_probe) begin
				pos_q <= pos_nxt;
				n_q   <= n_q + 1'b1;
			end
		end
		// result word: {pad, distinct_levels, level_count, level}
		priority if (fin_new) begin
			m_tdata_q <= {2'b00, lvl_new, NW'(1), lvl_new};
			m_tuser_q <= 2'b01;
		end else if (fin_full) begin
			m_tdata_q <= {2'b00, levels_used_q, NW'(0), LW'(0)};
			m_tuser_q <= 2'b10;
		end else if (fin_tally) begin
			m_tdata_q <= {2'b00, levels_used_q, tally_inc, lvl_q};
			m_tuser_q <= 2'b00;
		end else if (fin_cnt) begin
			m_tdata_q <= {2'b00, levels_used_q, (lidx_ok ? tally_rd : NW'(0)), LW'(0)};
			m_tuser_q <= 2'b00;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

FILE: sv/dlhm_ram.sv
// ----------------------------------------------------------------------------
// dlhm_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlhm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/dlhm_mod.sv
// ----------------------------------------------------------------------------
// dlhm_mod
// Iterative remainder of a 32-bit hash by the slot count, MOD_DIGIT bits/cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlhm_mod (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [31:0]                      dividend,
	input  logic [dlhm_pkg::SLOT_CNT_W-1:0]  divisor,
	output dlhm_pkg::mod_stat_t              stat
);

	logic                           busy_q;
	logic                           done_q;
	logic [dlhm_pkg::MOD_CW-1:0]    cnt_q;
	logic [31:0]                    dvd_q;
	logic [dlhm_pkg::SLOT_AW-1:0]   rem_q;
	logic [dlhm_pkg::SLOT_AW-1:0]   rem_nxt;
	logic [dlhm_pkg::SLOT_AW:0]     part;

	// restoring remainder, MOD_DIGIT dividend bits per cycle
	always_comb begin
		rem_nxt = rem_q;
		part    = '0;
		for (int i = 0; i < dlhm_pkg::MOD_DIGIT; i++) begin
			part = {rem_nxt, dvd_q[31 - i]};
			if (part >= divisor) begin
				rem_nxt = dlhm_pkg::SLOT_AW'(part - divisor);
			end else begin
				rem_nxt = part[dlhm_pkg::SLOT_AW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == dlhm_pkg::MOD_CW'(dlhm_pkg::MOD_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[31-dlhm_pkg::MOD_DIGIT:0], {dlhm_pkg::MOD_DIGIT{1'b0}}};
			rem_q <= rem_nxt;
		end
	end

	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

FILE: sv/dlhm_chk.sv
// ----------------------------------------------------------------------------
// dlhm_chk
// Port-level checks for the dense level ID hash map, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dense_level_id_hash_map_macros.svh"

module dlhm_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata,
	input logic [1:0]  m_tuser
);

	// a waiting result is not withdrawn
	`DLHM_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// one item in flight: no second input right after an input transfer
	`DLHM_ASSERT_NEXT(a_one_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// full table gives level 0, no insert, zero count
	`DLHM_ASSERT_NOW(a_full_res, clk, arst_n, m_tvalid && m_tuser[1],
		m_tdata[10:0] == 11'd0 && !m_tuser[0] && m_tdata[42:11] == 32'd0)

	// a new key takes the newest level with a count of one
	`DLHM_ASSERT_NOW(a_new_res, clk, arst_n, m_tvalid && m_tuser[0],
		m_tdata[10:0] == m_tdata[53:43] && m_tdata[42:11] == 32'd1)

endmodule

bind dense_level_id_hash_map dlhm_chk u_dlhm_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: verif/dlhm_checker.sv
// ----------------------------------------------------------------------------
// dlhm_checker
// Watches the config port and both streams of the level ID hash map, keeps its
// own copy of the slot table and level tallies, and compares each result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dlhm_checker
	import dlhm_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [47:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [55:0] m_tdata,
	input  logic [1:0]  m_tuser,
	output int          failures,
	output int          outstanding
);

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               is_new;
		logic               full;
		logic [COUNT_W-1:0] count;
		logic [LEVEL_W-1:0] distinct;
	} answer_t;

	answer_t answers_due[$];

	logic [KEY_W-1:0]   held_key   [TABLE_SLOTS];
	bit                 slot_taken [TABLE_SLOTS];
	logic [LEVEL_W-1:0] held_level [TABLE_SLOTS];
	logic [COUNT_W-1:0] tally      [TABLE_SLOTS];
	int unsigned        levels_seen = 0;
	logic [CFG_W-1:0]   slots_reg = CFG_W'(TABLE_SLOTS);
	int                 mismatches = 0;
	int                 due_count = 0;

	assign failures    = mismatches;
	assign outstanding = due_count;

	initial begin
		for (int i = 0; i < TABLE_SLOTS; i++) begin
			slot_taken[i] = 1'b0;
			tally[i]      = '0;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] seen,
	                               input logic [31:0] wanted);
		$display("%0t ns: %s mismatch, got 0x%0h, want 0x%0h", $time, what, seen, wanted);
		mismatches++;
	endtask

	// hash, probe, insert if free, bump the level tally
	task automatic map_key(input logic [KEY_W-1:0] k, output answer_t a);
		int unsigned m;
		int unsigned pos;
		int unsigned n;
		logic [31:0] h;
		bit          done;
		m = slots_reg;
		if (m == 0) m = 1;
		if (m > TABLE_SLOTS) m = TABLE_SLOTS;
		h    = k * HASH_MULT;
		pos  = h % m;
		a    = '0;
		done = 1'b0;
		for (n = 0; n < m && !done; n++) begin
			if (!slot_taken[pos]) begin
				levels_seen++;
				slot_taken[pos] = 1'b1;
				held_key[pos]   = k;
				held_level[pos] = LEVEL_W'(levels_seen);
				a.level         = LEVEL_W'(levels_seen);
				a.is_new        = 1'b1;
				done            = 1'b1;
			end else if (held_key[pos] == k) begin
				a.level = held_level[pos];
				done    = 1'b1;
			end else begin
				pos = (pos + 1 == m) ? 0 : pos + 1;
			end
		end
		if (!done) begin
			a.full = 1'b1;
		end else if (a.level >= 1 && a.level <= TABLE_SLOTS) begin
			if (tally[a.level - 1] != COUNT_MAX) tally[a.level - 1]++;
			a.count = tally[a.level - 1];
		end
		a.distinct = LEVEL_W'(levels_seen);
	endtask

	task automatic read_tally(input logic [LEVEL_W-1:0] idx, output answer_t a);
		a = '0;
		if (idx != 0 && idx <= levels_seen && idx <= TABLE_SLOTS) a.count = tally[idx - 1];
		a.distinct = LEVEL_W'(levels_seen);
	endtask

	always @(posedge clk) begin
		answer_t want;
		answer_t got;
		if (arst_n) begin
			if (cfg_we) slots_reg = cfg_wdata;
			if (s_tvalid && s_tready) begin
				// tuser high means a tally read
				if (s_tuser) read_tally(s_tdata[42:32], want);
				else map_key(s_tdata[31:0], want);
				answers_due.push_back(want);
			end
			if (m_tvalid && m_tready) begin
				got.level    = m_tdata[10:0];
				got.count    = m_tdata[42:11];
				got.distinct = m_tdata[53:43];
				got.is_new   = m_tuser[0];
				got.full     = m_tuser[1];
				if (answers_due.size() == 0) begin
					report_mismatch("unrequested result", 32'(m_tdata[10:0]), 32'd0);
				end else begin
					want = answers_due.pop_front();
					if (got.level != want.level)
						report_mismatch("level", 32'(got.level), 32'(want.level));
					if (got.is_new != want.is_new)
						report_mismatch("is_new", 32'(got.is_new), 32'(want.is_new));
					if (got.full != want.full)
						report_mismatch("table_full", 32'(got.full), 32'(want.full));
					if (got.count != want.count)
						report_mismatch("level_count", got.count, want.count);
					if (got.distinct != want.distinct)
						report_mismatch("distinct_levels", 32'(got.distinct),
						                32'(want.distinct));
				end
			end
			due_count <= answers_due.size();
		end
	end

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the level ID hash map through directed corner cases and random
// phases at several slot counts; the checker predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

	import dlhm_pkg::*;

	// tuser function codes
	localparam logic FUNC_MAP  = 1'b0;   // insert or look up a key
	localparam logic FUNC_READ = 1'b1;   // read the tally of one level

	localparam int ITEMS_PER_PHASE = 200;
	localparam int SETTLE_CYCLES   = 20;
	localparam int DRAIN_CYCLES    = 50;
	localparam int HOLD_CYCLES     = 400;
	localparam int HOLD_AFTER      = 600;
	localparam int CALM_PHASE      = 7;
	// worst case per item: full sweep of 1024 slots plus hash, stalls and gaps,
	// times ~1900 items, plus the clearing pass; taken with ample margin
	localparam int CYCLE_LIMIT     = 6_000_000;

	// slot counts of the random phases, phase 0 in the low bits:
	// 1024, 1, 7, 2047 (clamped), 100, 3, 1023, 512, 1024
	localparam logic [8:0][10:0] PHASE_SLOTS = {11'd1024, 11'd512, 11'd1023, 11'd3,
	                                             11'd100, 11'd2047, 11'd7, 11'd1, 11'd1024};

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [10:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;   // [31:0] key, [42:32] level_index, [47:43] zero
	logic        s_tuser   = 1'b0; // [0] func
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [55:0] m_tdata;          // [10:0] level, [42:11] level_count,
	                               // [53:43] distinct_levels, [55:54] zero
	logic [1:0]  m_tuser;          // [0] is_new, [1] table_full

	int          failures;
	int          outstanding;
	int          cycles     = 0;
	int          items_sent = 0;
	bit          calm       = 1'b0;   // no gaps and no stalls while set
	logic [31:0] sent_keys[$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	dense_level_id_hash_map i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	dlhm_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.failures    (failures),
		.outstanding (outstanding)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Offer one transfer after a random gap; returns at the accepting edge so a
	// back-to-back transfer keeps tvalid high without a second assignment.
	task automatic send_item(input logic func, input logic [31:0] k, input logic [10:0] idx);
		int roll;
		int gap;
		roll = $urandom_range(0, 99);
		if (calm || roll < 55) gap = 0;
		else if (roll < 90) gap = $urandom_range(1, 3);
		else gap = $urandom_range(5, 40);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, idx, k};
		s_tuser  <= func;
		do @(posedge clk); while (!s_tready);
		items_sent++;
	endtask

	task automatic map_key(input logic [31:0] k);
		sent_keys.push_back(k);
		send_item(FUNC_MAP, k, 11'($urandom_range(0, 1024)));
	endtask

	task automatic read_level(input logic [10:0] idx);
		send_item(FUNC_READ, $urandom, idx);
	endtask

	// slot count may only change with nothing in flight
	task automatic set_slots(input logic [10:0] value);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// result side: mostly ready, short stalls, a few long ones, and one long
	// hold-off so the block backs up and stalls its input
	initial begin
		bit held;
		held = 1'b0;
		@(posedge clk);
		forever begin
			if (!held && items_sent >= HOLD_AFTER) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				held = 1'b1;
			end else if (calm) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
						m_tready <= 1'b1;
						repeat ($urandom_range(1, 30)) @(posedge clk);
					end
					19: begin
						m_tready <= 1'b0;
						repeat ($urandom_range(10, 60)) @(posedge clk);
					end
					default: begin
						m_tready <= 1'b0;
						repeat ($urandom_range(1, 3)) @(posedge clk);
					end
				endcase
			end
		end
	end

	initial begin
		int          roll;
		int          top_level;
		logic [31:0] k;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed, reset slot count: key extremes, repeats, all-ones key
		map_key(32'h0000_0000);
		map_key(32'h0000_0000);
		map_key(32'hFFFF_FFFF);
		map_key(32'hFFFF_FFFF);
		map_key(32'h7FFF_FFFF);
		map_key(32'h8000_0000);
		map_key(32'h0000_0001);
		read_level(11'd0);      // level zero reads as empty
		read_level(11'd1);
		read_level(11'd5);      // highest level in use
		read_level(11'd6);      // one past the levels in use
		read_level(11'd1024);
		map_key(32'h8000_0000);

		// slot count zero acts as one: only the key in slot 0 is seen, others are full
		set_slots(11'd0);
		map_key(32'h0000_0000);
		map_key(32'd12345);
		map_key(32'hFFFF_FFFF);

		// two slots, both already taken: keys 1 and 2 find a full table, key 0 is found
		set_slots(11'd2);
		map_key(32'h0000_0001);
		map_key(32'h0000_0002);
		map_key(32'h0000_0000);
		read_level(11'd6);

		// random phases: reuse of known keys dominates so the table stays at
		// moderate load; small slot counts hit the full case often
		for (int phase = 0; phase < 9; phase++) begin
			set_slots(PHASE_SLOTS[phase]);
			calm = (phase == CALM_PHASE);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 20) begin
					top_level = (sent_keys.size() < 1024) ? sent_keys.size() : 1024;
					if (roll < 14) read_level(11'($urandom_range(1, top_level)));
					else read_level(11'($urandom_range(0, 1024)));
				end else begin
					if (roll < 32) begin
						case ($urandom_range(0, 4))
							0: k = 32'h0000_0000;
							1: k = 32'hFFFF_FFFF;
							2: k = 32'h7FFF_FFFF;
							3: k = 32'h8000_0000;
							default: k = 32'h0000_0001;
						endcase
					end else if (roll < 52) begin
						k = $urandom;
					end else begin
						k = sent_keys[$urandom_range(0, sent_keys.size() - 1)];
					end
					map_key(k);
				end
			end
		end
		calm = 1'b0;

		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
+incdir+sv
sv/dlhm_pkg.sv
sv/dlhm_ram.sv
sv/dlhm_mod.sv
sv/dense_level_id_hash_map.sv
sv/dlhm_chk.sv
verif/dlhm_checker.sv
verif/testbench.sv
